[rtl/fcoa_pkg.sv]
// Package with the types, constants and helpers shared by the chain offset mapper.
package fcoa_pkg;

	// Geometry of the allocation table and of the file layout.
	localparam int NUM_BLOCKS   = 4096;
	localparam int TBL_AW       = $clog2(NUM_BLOCKS);
	localparam int BLK_W        = 12;
	localparam int BLOCK_SHIFT  = 9;
	localparam int HEADER_BYTES = 8;
	localparam int LEN_W        = 22;
	localparam int ADDR_W       = 21;
	localparam int WORD_W       = 32;
	localparam int POS_W        = LEN_W + 1;
	localparam int HOP_W        = POS_W - BLOCK_SHIFT;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 22;
	localparam logic [CFG_IDX_W-1:0] CFG_START_BLOCK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILE_LENGTH = 1'd1;

	// Item operations and result status codes.
	localparam logic       OP_LOAD          = 1'b0;
	localparam logic       OP_READ          = 1'b1;
	localparam logic [1:0] STATUS_MAPPED    = 2'd0;
	localparam logic [1:0] STATUS_RANGE_ERR = 2'd1;
	localparam logic [1:0] STATUS_STORED    = 2'd2;

	typedef struct packed {
		logic                op;
		logic [BLK_W-1:0]    table_index;
		logic [BLK_W-1:0]    table_value;
		logic [WORD_W-1:0]   byte_offset;
		logic [WORD_W-1:0]   request_length;
	} item_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [ADDR_W-1:0]   device_address;
		logic [LEN_W-1:0]    byte_count;
	} result_t;

	typedef struct packed {
		logic [BLK_W-1:0]    start_block;
		logic [LEN_W-1:0]    file_length;
	} cfg_t;

	typedef struct packed {
		logic                we;
		logic [TBL_AW-1:0]   waddr;
		logic [BLK_W-1:0]    wdata;
		logic                re;
		logic [TBL_AW-1:0]   raddr;
	} tbl_req_t;

	typedef enum logic [1:0] {
		WS_IDLE,
		WS_EVAL,
		WS_WALK,
		WS_DONE
	} walk_state_t;

	// True when a block number has an entry in the table.
	function automatic logic in_table(input logic [BLK_W-1:0] blk);
		return (32'(blk) < 32'(NUM_BLOCKS));
	endfunction

	function automatic logic [TBL_AW-1:0] tbl_addr(input logic [BLK_W-1:0] blk);
		return TBL_AW'(blk);
	endfunction

endpackage

[rtl/fcoa_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module fcoa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/fcoa_walk.sv]
// Sequencer that stores table entries and walks the block chain for a read.
module fcoa_walk import fcoa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  item_t             item,
	output logic              item_ready,
	input  cfg_t              cfg,
	input  logic              out_free,
	output logic              res_fire,
	output result_t           res,
	output tbl_req_t          tbl,
	input  logic [BLK_W-1:0]  tbl_rdata
);

	walk_state_t        state_q, state_d;
	logic [WORD_W-1:0]  off_q;
	logic [WORD_W-1:0]  req_q;
	logic [HOP_W-1:0]   rem_q;
	logic [BLOCK_SHIFT-1:0] inblk_q;
	logic               in_range_q;
	result_t            res_q;

	logic               err;
	logic [LEN_W-1:0]   remain;
	logic [LEN_W-1:0]   count;
	logic [POS_W-1:0]   pos;
	logic [HOP_W-1:0]   hops;
	logic [BLOCK_SHIFT-1:0] inblk;
	logic [BLK_W-1:0]   cur;
	logic               accept;

	// Offset checks and clamping; only meaningful in the evaluate state.
	always_comb begin
		err    = off_q > WORD_W'(cfg.file_length);
		remain = cfg.file_length - off_q[LEN_W-1:0];
		count  = (req_q < WORD_W'(remain)) ? req_q[LEN_W-1:0] : remain;
		pos    = POS_W'(off_q[LEN_W-1:0]) + POS_W'(HEADER_BYTES);
		hops   = pos[POS_W-1:BLOCK_SHIFT];
		inblk  = pos[BLOCK_SHIFT-1:0];
	end

	// A block beyond the table reads as block zero.
	assign cur    = in_range_q ? tbl_rdata : '0;
	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		res_fire   = 1'b0;
		res        = res_q;
		tbl        = '0;
		case (state_q)
			WS_IDLE: begin
				item_ready = out_free;
				if (item_valid && out_free) begin
					if (item.op == OP_LOAD) begin
						tbl.we    = in_table(item.table_index);
						tbl.waddr = tbl_addr(item.table_index);
						tbl.wdata = item.table_value;
						res_fire  = 1'b1;
						res       = '{status: STATUS_STORED, device_address: '0,
						              byte_count: '0};
					end else begin
						state_d = WS_EVAL;
					end
				end
			end
			WS_EVAL: begin
				if (err || hops == '0) begin
					state_d = WS_DONE;
				end else begin
					tbl.re    = 1'b1;
					tbl.raddr = tbl_addr(cfg.start_block);
					state_d   = WS_WALK;
				end
			end
			WS_WALK: begin
				if (rem_q == HOP_W'(1)) begin
					state_d = WS_DONE;
				end else begin
					tbl.re    = 1'b1;
					tbl.raddr = tbl_addr(cur);
				end
			end
			WS_DONE: begin
				if (out_free) begin
					res_fire = 1'b1;
					state_d  = WS_IDLE;
				end
			end
			default: begin
				state_d = WS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == OP_READ) begin
			off_q <= item.byte_offset;
			req_q <= item.request_length;
		end
		if (state_q == WS_EVAL) begin
			res_q.status         <= err ? STATUS_RANGE_ERR : STATUS_MAPPED;
			res_q.byte_count     <= err ? '0 : count;
			res_q.device_address <= err ? '0 : {cfg.start_block, inblk};
			inblk_q              <= inblk;
			rem_q                <= hops;
			in_range_q           <= in_table(cfg.start_block);
		end
		if (state_q == WS_WALK) begin
			rem_q      <= rem_q - HOP_W'(1);
			in_range_q <= in_table(cur);
			if (rem_q == HOP_W'(1)) begin
				res_q.device_address <= {cur, inblk_q};
			end
		end
	end

	// Every hop consumes the read issued in the cycle before.
	a_hop_has_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WS_WALK |-> $past(tbl.re))
		else $error("chain hop without a preceding table read");

	a_hops_left: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == WS_WALK |-> rem_q != '0)
		else $error("chain walk running with no hops left");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == WS_DONE && res_q.status == STATUS_MAPPED)
			|-> res_q.byte_count <= cfg.file_length)
		else $error("byte count exceeds the file length");

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		tbl.we |-> !tbl.re)
		else $error("table written while a walk read is issued");

endmodule

[rtl/fat_chain_offset_to_address.sv]
// Top level of the file offset to device address mapper with its chain table.
// A load transfer is stored and answered at its acceptance edge.
// A read transfer walks n = (byte_offset + 8) / 512 chain hops, one hop per cycle
// through the table RAM's registered read port; out-of-range offsets walk none.
// Throughput: one item at a time; the next is taken once the walk is over and the
// output register has room. Reset clears control and configuration; the table is not.
module fat_chain_offset_to_address import fcoa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  item_t                 item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [BLK_W-1:0]  start_block_q;
	logic [LEN_W-1:0]  file_length_q;
	cfg_t              cfg;
	result_t           result_q;
	logic              result_valid_q;
	logic              out_free;
	logic              res_fire;
	result_t           res;
	tbl_req_t          tbl;
	logic [BLK_W-1:0]  tbl_rdata;

	// The user must write configuration only while the mapper is idle; the block does
	// not enforce it. The registers are always ready and take each transfer immediately.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_block_q <= '0;
			file_length_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_START_BLOCK: start_block_q <= cfg_data[BLK_W-1:0];
				CFG_FILE_LENGTH: file_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = '{start_block: start_block_q, file_length: file_length_q};

	// The output register holds a finished result until its transfer completes.
	// It can take a new result in the same cycle in which the old one leaves.
	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (res_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			result_q <= res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The sequencer writes table entries on loads and walks the chain on reads.
	// Loads are taken only while no walk is running, so a read never meets a
	// write to the same entry and no forwarding is needed.
	fcoa_walk u_walk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.cfg        (cfg),
		.out_free   (out_free),
		.res_fire   (res_fire),
		.res        (res),
		.tbl        (tbl),
		.tbl_rdata  (tbl_rdata)
	);

	// The allocation table: one next-block number per block.
	fcoa_ram #(
		.WIDTH (BLK_W),
		.DEPTH (NUM_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (tbl.we),
		.waddr (tbl.waddr),
		.wdata (tbl.wdata),
		.re    (tbl.re),
		.raddr (tbl.raddr),
		.rdata (tbl_rdata)
	);

endmodule

[sim/fat_chain_offset_to_address_chk.sv]
// Checker for the chain offset mapper: watches all three channels, predicts and compares.
module fat_chain_offset_to_address_chk import fcoa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  item_ready,
	input  item_t                 item,
	input  logic                  result_valid,
	input  logic                  result_ready,
	input  result_t               result,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending,
	output int                    results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [BLK_W-1:0] chain_copy [NUM_BLOCKS];
	logic [BLK_W-1:0] start_copy;
	logic [LEN_W-1:0] length_copy;
	result_t          awaited_results [$];
	int               n_fail    = 0;
	int               n_checked = 0;
	int               n_waiting = 0;

	assign fail_count      = n_fail;
	assign pending         = n_waiting;
	assign results_checked = n_checked;

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("%0t ns ERROR: result %0d, %s: expected 0x%0h, got 0x%0h",
			$time, n_checked, what, want, got);
		n_fail++;
	endtask

	// Works out the result of one item and applies a load to the local table copy.
	function automatic result_t predict_mapping(input item_t it);
		result_t          r;
		logic [31:0]      remain;
		logic [POS_W-1:0] pos;
		logic [BLK_W-1:0] blk;
		r = '0;
		if (it.op == OP_LOAD) begin
			chain_copy[it.table_index] = it.table_value;
			r.status = STATUS_STORED;
		end else if (it.byte_offset > 32'(length_copy)) begin
			r.status = STATUS_RANGE_ERR;
		end else begin
			remain       = 32'(length_copy) - it.byte_offset;
			r.byte_count = LEN_W'((it.request_length < remain) ? it.request_length : remain);
			pos          = POS_W'(it.byte_offset) + POS_W'(HEADER_BYTES);
			blk          = start_copy;
			for (int i = 0; i < int'(pos >> BLOCK_SHIFT); i++)
				blk = chain_copy[blk];
			r.device_address = ADDR_W'({blk, pos[BLOCK_SHIFT-1:0]});
			r.status         = STATUS_MAPPED;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			start_copy  = '0;
			length_copy = '0;
			n_waiting   = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_BLOCK: start_copy = cfg_data[BLK_W-1:0];
					CFG_FILE_LENGTH: length_copy = cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("result with nothing awaited, status", '0,
						32'(result.status));
				end else begin
					want = awaited_results.pop_front();
					if (result.status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(result.status));
					if (result.device_address !== want.device_address)
						report_mismatch("device_address", 32'(want.device_address),
							32'(result.device_address));
					if (result.byte_count !== want.byte_count)
						report_mismatch("byte_count", 32'(want.byte_count),
							32'(result.byte_count));
				end
				n_checked++;
			end
			if (item_valid && item_ready)
				awaited_results.push_back(predict_mapping(item));
			n_waiting = awaited_results.size();
		end
	end

endmodule

[sim/fat_chain_offset_to_address_tb.sv]
// Testbench top for the chain offset mapper: clock, reset, stimulus and verdict.
module fat_chain_offset_to_address_tb import fcoa_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          ITEM_TARGET = 450;
	localparam int unsigned FULL_LENGTH = 2097152;
	localparam int unsigned BLOCK_BYTES = 1 << BLOCK_SHIFT;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	item_t                 item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	result_t               result;
	logic                  cfg_valid    = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index    = CFG_START_BLOCK;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;

	int fail_count;
	int pending;
	int results_checked;

	// Stimulus-side picture of the table: which entries have been written and where
	// each one points. A read is only issued when every hop it needs lands on an entry
	// that has been written, since the table holds no defined value before that.
	bit               written  [NUM_BLOCKS];
	logic [BLK_W-1:0] next_blk [NUM_BLOCKS];
	logic [BLK_W-1:0] cur_start;
	logic [LEN_W-1:0] cur_length;

	// When calm is set neither side idles, giving stretches of back-to-back transfers.
	bit calm       = 1'b0;
	int stall_left = 0;
	int items_sent = 0;
	int n_loads    = 0;
	int n_reads    = 0;
	int n_settings = 0;

	always #2 clk = ~clk;

	fat_chain_offset_to_address uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	fat_chain_offset_to_address_chk chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.pending         (pending),
		.results_checked (results_checked)
	);

	// The result side holds ready low in random bursts. Exactly one
	// assignment to result_ready is made at every falling edge.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			result_ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left   <= $urandom_range(0, 12);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	// Writes one configuration register and waits for the transfer. Valid stays high
	// into the next write; configure() lowers it once both registers are done.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic configure(input logic [BLK_W-1:0] blk, input logic [LEN_W-1:0] len);
		write_reg(CFG_START_BLOCK, CFG_DATA_W'(blk));
		write_reg(CFG_FILE_LENGTH, CFG_DATA_W'(len));
		@(negedge clk);
		cfg_valid  <= 1'b0;
		cur_start  = blk;
		cur_length = len;
		n_settings++;
	endtask

	// Presents one item, sometimes after an idle gap, and returns once it is taken.
	// Valid is left high so that the next item can follow without a bubble.
	task automatic send_item(input item_t it);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13))
				@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		items_sent++;
		if (it.op == OP_LOAD) begin
			written[it.table_index]  = 1'b1;
			next_blk[it.table_index] = it.table_value;
			n_loads++;
		end else begin
			n_reads++;
		end
	endtask

	// The fields a load does not use still carry random bits.
	task automatic load_entry(input logic [BLK_W-1:0] idx, input logic [BLK_W-1:0] val);
		item_t it;
		it.op             = OP_LOAD;
		it.table_index    = idx;
		it.table_value    = val;
		it.byte_offset    = $urandom;
		it.request_length = $urandom;
		send_item(it);
	endtask

	task automatic read_at(input logic [31:0] offset, input logic [31:0] len);
		item_t it;
		it.op             = OP_READ;
		it.table_index    = BLK_W'($urandom);
		it.table_value    = BLK_W'($urandom);
		it.byte_offset    = offset;
		it.request_length = len;
		send_item(it);
	endtask

	// Number of hops from the start block that only pass through written entries,
	// stopping at cap. A loop in the chain lets the walk reach the cap.
	function automatic int unsigned walkable_hops(input int unsigned cap);
		int unsigned      h;
		logic [BLK_W-1:0] b;
		h = 0;
		b = cur_start;
		while (h < cap && written[b]) begin
			b = next_blk[b];
			h++;
		end
		return h;
	endfunction

	// A read that mostly stays inside the file and the walkable part of the chain,
	// with some offsets past the end, on the end itself and on block boundaries.
	task automatic random_read();
		int unsigned cap;
		int unsigned max_ok;
		int unsigned k;
		logic [31:0] off;
		logic [31:0] len;
		cap    = (int'(cur_length) + HEADER_BYTES) >> BLOCK_SHIFT;
		max_ok = walkable_hops(cap) * BLOCK_BYTES + BLOCK_BYTES - 1 - HEADER_BYTES;
		if (max_ok > cur_length)
			max_ok = cur_length;
		case ($urandom_range(0, 9))
			0, 1: begin
				if ($urandom_range(0, 1) == 0)
					off = 32'(cur_length) + 1;
				else
					off = 32'(cur_length) + 1
						+ $urandom_range(0, 32'hFFFF_FFFF - 32'(cur_length) - 1);
			end
			2: off = max_ok;
			3: begin
				k   = $urandom_range(0, (max_ok + HEADER_BYTES) >> BLOCK_SHIFT);
				off = (k == 0) ? 32'd0 : k * BLOCK_BYTES - HEADER_BYTES;
				if (off != 0 && $urandom_range(0, 1) == 0)
					off = off - 1;
			end
			default: off = $urandom_range(0, max_ok);
		endcase
		case ($urandom_range(0, 3))
			0: len = $urandom;
			1: len = $urandom_range(0, 1024);
			2: len = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'hFFFF_FFFF;
			default: len = 32'(cur_length) - off + $urandom_range(0, 2) - 1;
		endcase
		read_at(off, len);
	endtask

	// Lowers item valid and waits until every result is back and the block is quiet.
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (8)
			@(posedge clk);
	endtask

	// One configuration setting: a freshly laid chain from the start block, then a mix
	// of reads and stray loads. Long files always get a loop so that deep reads walk.
	task automatic run_phase(input logic [BLK_W-1:0] blk, input logic [LEN_W-1:0] len,
			input int n_items, input bit quiet);
		logic [BLK_W-1:0] chain [16];
		int               chain_len;
		bit               looped;
		wait_idle();
		calm = quiet;
		configure(blk, len);
		chain_len = $urandom_range(1, 12);
		looped    = (len > 65536) || ($urandom_range(0, 1) == 0);
		chain[0]  = blk;
		for (int j = 1; j < chain_len; j++)
			chain[j] = BLK_W'($urandom);
		for (int j = 0; j + 1 < chain_len; j++)
			load_entry(chain[j], chain[j+1]);
		if (looped)
			load_entry(chain[chain_len-1], chain[$urandom_range(0, chain_len - 1)]);
		else
			load_entry(chain[chain_len-1], BLK_W'($urandom));
		repeat (n_items) begin
			if ($urandom_range(0, 4) == 0)
				load_entry(BLK_W'($urandom), BLK_W'($urandom));
			else
				random_read();
		end
	endtask

	initial begin
		int               phase_no;
		logic [BLK_W-1:0] blk;
		logic [LEN_W-1:0] len;
		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2)
			@(posedge clk);

		// Directed part: the highest start block with the longest file, linked in a
		// two-entry loop through entry zero. Reads cover no hop, the first hop at a
		// block boundary, the offset equal to the length, offsets past the end up to
		// the largest value, and clamping of the longest request.
		configure(BLK_W'(NUM_BLOCKS - 1), LEN_W'(FULL_LENGTH));
		load_entry(BLK_W'(NUM_BLOCKS - 1), '0);
		load_entry('0, BLK_W'(NUM_BLOCKS - 1));
		read_at(32'd0, 32'd0);
		read_at(BLOCK_BYTES - 1 - HEADER_BYTES, 32'd1);
		read_at(BLOCK_BYTES - HEADER_BYTES, 32'hFFFF_FFFF);
		read_at(32'd0, 32'hFFFF_FFFF);
		read_at(32'd1000, 32'd7);
		read_at(FULL_LENGTH, 32'd100);
		read_at(FULL_LENGTH + 1, 32'd100);
		read_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// An empty file: offset zero maps with nothing left, offset one is past the end.
		wait_idle();
		configure('0, '0);
		read_at(32'd0, 32'd5);
		read_at(32'd1, 32'd5);
		load_entry(BLK_W'(NUM_BLOCKS - 1), BLK_W'(NUM_BLOCKS - 1));

		// Random part, cycling through settings that include the extremes.
		phase_no = 0;
		while (items_sent < ITEM_TARGET - 40) begin
			case (phase_no % 5)
				0: begin
					blk = '0;
					len = LEN_W'($urandom_range(0, 6000));
				end
				1: begin
					blk = BLK_W'(NUM_BLOCKS - 1);
					len = LEN_W'(FULL_LENGTH);
				end
				2: begin
					blk = BLK_W'($urandom);
					len = LEN_W'($urandom_range(0, 4000));
				end
				3: begin
					blk = BLK_W'($urandom);
					len = LEN_W'($urandom_range(0, FULL_LENGTH));
				end
				default: begin
					blk = BLK_W'($urandom);
					len = LEN_W'($urandom_range(0, 40));
				end
			endcase
			run_phase(blk, len, (len > 65536) ? 12 : $urandom_range(20, 40),
				$urandom_range(0, 3) == 0);
			phase_no++;
		end

		// Closing phase with both sides running flat out.
		run_phase(BLK_W'($urandom), LEN_W'($urandom_range(512, 8000)), 30, 1'b1);
		wait_idle();
		repeat (20)
			@(posedge clk);

		$display("Run covered %0d item transfers (%0d loads, %0d reads) over %0d settings.",
			items_sent, n_loads, n_reads, n_settings);
		$display("%0d results were compared with the prediction.", results_checked);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Guard against a hang: far longer than the slowest correct run needs.
	initial begin
		#20_000_000;
		$display("Timeout with %0d results outstanding.", pending);
		$display("Mismatches found");
		$finish;
	end

endmodule
